// File: rtl/bdq_pkg.sv
// bdq_pkg: shared types, codes and sizes for the bounded deque core
// depends on nothing; imported by the channel interfaces, the cells, the top level and the checker
`timescale 1ns / 1ps

package bdq_pkg;

   // storage depth of the cell chain
   localparam int DEPTH = 16;

   // fixed field widths
   localparam int ACTION_W    = 3;
   localparam int VALUE_W     = 32;
   localparam int POSITION_W  = 5;
   localparam int COUNT_OUT_W = 5;
   localparam int STATUS_W    = 2;

   // derived internal widths
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int IDX_W = $clog2(DEPTH);
   localparam int CMP_W = (CNT_W > POSITION_W) ? CNT_W : POSITION_W;

   typedef logic signed [VALUE_W-1:0] value_type;

   typedef enum logic [ACTION_W-1:0] {
      ACT_PUSH_FRONT = 3'd0,
      ACT_PUSH_BACK  = 3'd1,
      ACT_POP_FRONT  = 3'd2,
      ACT_POP_BACK   = 3'd3,
      ACT_INSERT_AT  = 3'd4,
      ACT_READ_AT    = 3'd5
   } action_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK     = 2'd0,
      ST_EMPTY  = 2'd1,
      ST_FULL   = 2'd2,
      ST_BADPOS = 2'd3
   } status_type;

   // what one cell does at the next edge
   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_LOAD,
      CELL_FROM_PREV,
      CELL_FROM_NEXT
   } cell_op_type;

   typedef struct packed {
      cell_op_type op;
      value_type   load_value;
   } cell_ctl_type;

endpackage

// File: rtl/bdq_req_if.sv
// bdq_req_if: request channel (valid/ready plus request payload)
// depends on bdq_pkg for field widths
`timescale 1ns / 1ps

interface bdq_req_if;
   import bdq_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [ACTION_W-1:0]   action;
   value_type             value_in;
   logic [POSITION_W-1:0] position;

   modport source (output valid, output action, output value_in, output position,
                   input ready);
   modport sink   (input valid, input action, input value_in, input position,
                   output ready);
endinterface

// File: rtl/bdq_rsp_if.sv
// bdq_rsp_if: response channel (valid/ready plus response payload)
// depends on bdq_pkg for field widths
`timescale 1ns / 1ps

interface bdq_rsp_if;
   import bdq_pkg::*;

   logic                   valid;
   logic                   ready;
   value_type              value_out;
   logic [COUNT_OUT_W-1:0] entry_count;
   logic [STATUS_W-1:0]    status;

   modport source (output valid, output value_out, output entry_count, output status,
                   input ready);
   modport sink   (input valid, input value_out, input entry_count, input status,
                   output ready);
endinterface

// File: rtl/bdq_cell.sv
// bdq_cell: one storage cell of the deque chain
// depends on bdq_pkg; takes its neighbours' values and a control word each cycle
`timescale 1ns / 1ps

module bdq_cell (
   input  logic                 clock,
   input  bdq_pkg::value_type    prev_value,
   input  bdq_pkg::value_type    next_value,
   input  bdq_pkg::cell_ctl_type ctl,
   output bdq_pkg::value_type    entry_value
);
   import bdq_pkg::*;

   value_type entry_ff;
   value_type entry_in;

   always_comb begin
      case (ctl.op)
         CELL_LOAD:      entry_in = ctl.load_value;
         CELL_FROM_PREV: entry_in = prev_value;
         CELL_FROM_NEXT: entry_in = next_value;
         default:        entry_in = entry_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry_value = entry_ff;

endmodule

// File: rtl/bounded_deque_insert_core.sv
// bounded_deque_insert_core: top level of the bounded deque
// depends on bdq_pkg, bdq_req_if, bdq_rsp_if and bdq_cell
`timescale 1ns / 1ps

// usage
// - req_chan carries one request per transfer: action, value_in, position
//   (push front/back, pop front/back, insert at a position, read at a position)
// - rsp_chan returns exactly one response per request: value_out, entry_count
//   and status (ok, empty, full, position out of range)
// - storage is a chain of DEPTH cells; every cell takes its own value, its
//   neighbour's value or the new value at once, so all later entries shift
//   together in the same cycle
// - latency: the response is valid in the cycle after the request transfer
// - throughput: one request per cycle while the receiver keeps up; the next
//   request is taken while the previous response is being transferred, as the
//   response sits in its own output register
// - if the receiver stalls, the response register holds and req_chan.ready
//   drops until it is taken; the deque state does not move meanwhile
// - reset clears the entry count and the response valid flag; cell contents
//   are not cleared, only entries below the count are ever read
// - unknown actions are answered with status ok and change nothing
module bounded_deque_insert_core (
   input  logic      clock,
   input  logic      reset,
   bdq_req_if.sink   req_chan,
   bdq_rsp_if.source rsp_chan
);
   import bdq_pkg::*;

   // entry count and response register
   logic [CNT_W-1:0]       count_ff;
   logic [CNT_W-1:0]       count_in;
   logic                   rsp_valid_ff;
   logic                   rsp_valid_in;
   value_type              rsp_value_ff;
   value_type              rsp_value_in;
   logic [COUNT_OUT_W-1:0] rsp_count_ff;
   status_type             rsp_status_ff;
   status_type             rsp_status_in;

   // cell chain wiring
   value_type    cell_value [DEPTH];
   value_type    prev_value [DEPTH];
   value_type    next_value [DEPTH];
   cell_ctl_type cell_ctl   [DEPTH];

   // request decode
   logic             req_xfer;
   logic             is_full;
   logic             is_empty;
   logic [CMP_W-1:0] pos_ext;
   logic [CMP_W-1:0] cnt_ext;
   logic             do_insert;
   logic             do_pop_front;
   logic             do_read;
   logic [CNT_W-1:0] insert_at;
   logic [IDX_W-1:0] read_idx;
   value_type        read_data;

   // a new request is taken whenever the output register is free or draining
   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign req_xfer       = req_chan.valid && req_chan.ready;

   assign is_full  = (count_ff == CNT_W'(DEPTH));
   assign is_empty = (count_ff == '0);
   assign pos_ext  = CMP_W'(req_chan.position);
   assign cnt_ext  = CMP_W'(count_ff);

   // decoder: status, count change, insert point and read address
   always_comb begin
      do_insert     = 1'b0;
      do_pop_front  = 1'b0;
      do_read       = 1'b0;
      insert_at     = '0;
      read_idx      = '0;
      count_in      = count_ff;
      rsp_status_in = ST_OK;
      unique case (req_chan.action) inside
         ACT_PUSH_FRONT, ACT_PUSH_BACK: begin
            if (is_full) begin
               rsp_status_in = ST_FULL;
            end else begin
               do_insert = 1'b1;
               insert_at = (req_chan.action == ACT_PUSH_FRONT) ? '0 : count_ff;
               count_in  = count_ff + CNT_W'(1);
            end
         end
         ACT_INSERT_AT: begin
            if (is_full) begin
               rsp_status_in = ST_FULL;
            end else if (pos_ext > cnt_ext) begin
               rsp_status_in = ST_BADPOS;
            end else begin
               do_insert = 1'b1;
               insert_at = CNT_W'(req_chan.position);
               count_in  = count_ff + CNT_W'(1);
            end
         end
         ACT_POP_FRONT: begin
            if (is_empty) begin
               rsp_status_in = ST_EMPTY;
            end else begin
               do_pop_front = 1'b1;
               do_read      = 1'b1;
               read_idx     = '0;
               count_in     = count_ff - CNT_W'(1);
            end
         end
         ACT_POP_BACK: begin
            if (is_empty) begin
               rsp_status_in = ST_EMPTY;
            end else begin
               do_read  = 1'b1;
               read_idx = IDX_W'(count_ff - CNT_W'(1));
               count_in = count_ff - CNT_W'(1);
            end
         end
         ACT_READ_AT: begin
            if (pos_ext >= cnt_ext) begin
               rsp_status_in = ST_BADPOS;
            end else begin
               do_read  = 1'b1;
               read_idx = IDX_W'(req_chan.position);
            end
         end
         default: begin
            // unknown action: no change, status ok
         end
      endcase
   end

   // single read port onto the chain for read, pop front and pop back
   assign read_data    = cell_value[read_idx];
   assign rsp_value_in = do_read ? read_data : '0;

   // per-cell control: insert opens a gap by shifting later cells back,
   // pop front shifts the whole chain forward by one
   always_comb begin
      for (int i = 0; i < DEPTH; i++) begin
         cell_ctl[i].load_value = req_chan.value_in;
         cell_ctl[i].op         = CELL_HOLD;
         if (req_xfer && do_insert) begin
            if (CNT_W'(i) == insert_at) begin
               cell_ctl[i].op = CELL_LOAD;
            end else if (CNT_W'(i) > insert_at) begin
               cell_ctl[i].op = CELL_FROM_PREV;
            end
         end else if (req_xfer && do_pop_front) begin
            cell_ctl[i].op = CELL_FROM_NEXT;
         end
      end
   end

   // neighbour links; the chain ends feed back their own value
   for (genvar g = 0; g < DEPTH; g++) begin : g_cell
      if (g == 0) begin : g_head
         assign prev_value[g] = cell_value[g];
      end else begin : g_prev
         assign prev_value[g] = cell_value[g-1];
      end
      if (g == DEPTH - 1) begin : g_tail
         assign next_value[g] = cell_value[g];
      end else begin : g_next
         assign next_value[g] = cell_value[g+1];
      end

      bdq_cell u_cell (
         .clock       (clock),
         .prev_value  (prev_value[g]),
         .next_value  (next_value[g]),
         .ctl         (cell_ctl[g]),
         .entry_value (cell_value[g])
      );
   end

   // response valid: set by a request transfer, cleared by a response transfer
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (req_xfer) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (req_xfer) begin
            count_ff <= count_in;
         end
      end
   end

   // response payload, loaded on each request transfer
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         rsp_value_ff  <= rsp_value_in;
         rsp_count_ff  <= COUNT_OUT_W'(count_in);
         rsp_status_ff <= rsp_status_in;
      end
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.value_out   = rsp_value_ff;
   assign rsp_chan.entry_count = rsp_count_ff;
   assign rsp_chan.status      = rsp_status_ff;

endmodule

// File: rtl/bdq_checker.sv
// bdq_checker: port-level assertions for the bounded deque core, and its bind
// depends on bdq_pkg; attached to bounded_deque_insert_core
`timescale 1ns / 1ps

module bdq_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_valid,
   input logic                            req_ready,
   input logic                            rsp_valid,
   input logic                            rsp_ready,
   input bdq_pkg::value_type              rsp_value_out,
   input logic [bdq_pkg::COUNT_OUT_W-1:0] rsp_entry_count,
   input logic [bdq_pkg::STATUS_W-1:0]    rsp_status
);
   import bdq_pkg::*;

   // a stalled response holds its payload
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_value_out)
         && $stable(rsp_entry_count) && $stable(rsp_status))
      else $error("stalled response changed");

   // every request transfer gives a response in the next cycle
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> rsp_valid)
      else $error("request transfer without response");

   // with no response pending the core takes requests
   assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("core stalled with empty output register");

   // empty status means nothing stored and nothing returned
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_EMPTY |-> rsp_entry_count == '0 && rsp_value_out == '0)
      else $error("empty status with stored entries or data");

   // full status means the chain is at depth and nothing is returned
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_FULL
         |-> rsp_entry_count == COUNT_OUT_W'(DEPTH) && rsp_value_out == '0)
      else $error("full status below depth");

endmodule

bind bounded_deque_insert_core bdq_checker u_bdq_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_chan.valid),
   .req_ready       (req_chan.ready),
   .rsp_valid       (rsp_chan.valid),
   .rsp_ready       (rsp_chan.ready),
   .rsp_value_out   (rsp_chan.value_out),
   .rsp_entry_count (rsp_chan.entry_count),
   .rsp_status      (rsp_chan.status)
);
